// ----- design/ifrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_pkg
// Shared types and constants for inverse-fitness roulette selection.
// ----------------------------------------------------------------------------
package ifrs_pkg;
	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int WT_W = 41;
	localparam int FIT_W = 32;
	localparam int OUT_IDX_W = 8;
	localparam int QDEPTH = 2;
	localparam int KIND_LOAD = 0;
	localparam int KIND_DRAW = 1;

	typedef struct packed {
		logic              kind;
		logic              first;
		logic [FIT_W-1:0]  operand;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADD,
		ST_MUL,
		ST_THR,
		ST_SRCH,
		ST_CMP,
		ST_RES
	} state_t;
endpackage

// ----- design/ifrs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_front
// Command queue between the start port and the execution engine.
// ----------------------------------------------------------------------------
module ifrs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ifrs_pkg::cmd_t     push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output ifrs_pkg::cmd_t     head
);
	ifrs_pkg::cmd_t mem_q [ifrs_pkg::QDEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(ifrs_pkg::QDEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && not_empty) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && not_empty);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(ifrs_pkg::QDEPTH)) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && cnt_q == 2'd1) |=> !not_empty) else $error("queue count");
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full) else $error("full dropped");
endmodule

// ----- design/ifrs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_back
// Executes loads (serial reciprocal divide) and draws (threshold multiply
// and binary search over the cumulative table).
// ----------------------------------------------------------------------------
module ifrs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  ifrs_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	output logic [ifrs_pkg::OUT_IDX_W-1:0] res_index,
	output logic               res_error
);
	localparam int W = ifrs_pkg::WT_W;
	localparam int IW = ifrs_pkg::IDX_W;
	localparam int CW = ifrs_pkg::CNT_W;

	ifrs_pkg::state_t state_q, state_d;
	ifrs_pkg::cmd_t cmd_q;
	logic [W-1:0] mem [ifrs_pkg::MAX_ENTRIES];
	logic [W-1:0] rd_data_q;
	logic [CW-1:0] count_q;
	logic [W-1:0] total_q;
	// divider: 33-bit dividend 2^32, restoring, one bit a cycle
	logic [31:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0] step_q;
	logic [63:0] plo_q, phi_q;
	logic [W-1:0] thr_q, weight_q;
	logic [IW-1:0] lo_q, hi_q, mid;
	logic [32:0] rem_sh, rem_sub;
	logic [W-1:0] new_total;

	assign rem_sh = {rem_q[31:0], (step_q == 6'd0)};
	assign rem_sub = rem_sh - {1'b0, cmd_q.operand};
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign new_total = ((cmd_q.first) ? '0 : total_q) + weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifrs_pkg::ST_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ifrs_pkg::ST_ADD) begin
				if (cmd_q.first) begin
					count_q <= CW'(1);
					total_q <= new_total;
				end else if (count_q < CW'(ifrs_pkg::MAX_ENTRIES)) begin
					count_q <= count_q + CW'(1);
					total_q <= new_total;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ifrs_pkg::ST_IDLE: begin
				cmd_q <= cmd;
				rem_q <= '0;
				quo_q <= '0;
				step_q <= '0;
			end
			ifrs_pkg::ST_DIV: begin
				step_q <= step_q + 6'd1;
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[31:0], 1'b0};
				end
				weight_q <= (cmd_q.operand <= 32'd1) ? W'(64'h1_0000_0000) : W'(quo_q);
			end
			ifrs_pkg::ST_ADD: begin
				if (cmd_q.first) begin
					mem[0] <= new_total;
				end else if (count_q < CW'(ifrs_pkg::MAX_ENTRIES)) begin
					mem[count_q[IW-1:0]] <= new_total;
				end
			end
			ifrs_pkg::ST_MUL: begin
				plo_q <= {32'd0, cmd_q.operand} * {32'd0, total_q[31:0]};
				phi_q <= {32'd0, cmd_q.operand} * {55'd0, total_q[W-1:32]};
				lo_q <= '0;
				hi_q <= IW'(count_q - CW'(1));
			end
			ifrs_pkg::ST_THR: begin
				thr_q <= W'(phi_q + {32'd0, plo_q[63:32]} + 64'(plo_q[31:0] != 32'd0));
			end
			ifrs_pkg::ST_SRCH: begin
				rd_data_q <= mem[mid];
			end
			ifrs_pkg::ST_CMP: begin
				if (rd_data_q >= thr_q) hi_q <= mid;
				else lo_q <= mid + IW'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_valid = 1'b0;
		res_index = ifrs_pkg::OUT_IDX_W'(lo_q);
		res_error = 1'b0;
		case (state_q)
			ifrs_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == 1'(ifrs_pkg::KIND_LOAD)) state_d = ifrs_pkg::ST_DIV;
					else state_d = ifrs_pkg::ST_MUL;
				end
			end
			ifrs_pkg::ST_DIV: if (step_q == 6'd33) state_d = ifrs_pkg::ST_ADD;
			ifrs_pkg::ST_ADD: state_d = ifrs_pkg::ST_IDLE;
			ifrs_pkg::ST_MUL: begin
				if (count_q == '0) state_d = ifrs_pkg::ST_RES;
				else state_d = ifrs_pkg::ST_THR;
			end
			ifrs_pkg::ST_THR: state_d = ifrs_pkg::ST_SRCH;
			ifrs_pkg::ST_SRCH: begin
				if (lo_q >= hi_q) state_d = ifrs_pkg::ST_RES;
				else state_d = ifrs_pkg::ST_CMP;
			end
			ifrs_pkg::ST_CMP: state_d = ifrs_pkg::ST_SRCH;
			ifrs_pkg::ST_RES: begin
				res_valid = 1'b1;
				res_error = (count_q == '0);
				if (count_q == '0) res_index = '0;
				state_d = ifrs_pkg::ST_IDLE;
			end
			default: state_d = ifrs_pkg::ST_IDLE;
		endcase
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ifrs_pkg::MAX_ENTRIES)) else $error("count overrun");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_error) |-> (count_q == '0 && res_index == '0))
		else $error("error result");
	a_res_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid) else $error("double result");
endmodule

// ----- design/inverse_fitness_roulette_select_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_fitness_roulette_select_top
// Roulette selection weighted by the Q1.32 reciprocal of each fitness value.
// ----------------------------------------------------------------------------
// Load: a 34-step serial divide in the engine, then a table write.
// Draw: threshold multiply, then binary search over the single table read port;
//   an empty table skips the search. The result shows one cycle on done.
// Throughput set by the engine; a two-entry queue takes start meanwhile.
// Reset clears count, total, queue and engine; table contents stay undefined.
// Receiver cannot stall: every result is a one-cycle strobe.
module inverse_fitness_roulette_select_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic        first,
	input  logic [31:0] fitness,
	input  logic [31:0] random_fraction,
	output logic        done,
	output logic [7:0]  chosen_index,
	output logic        empty_error
);
	ifrs_pkg::cmd_t in_cmd, head;
	logic full, not_empty, pop;

	// loads carry fitness, draws the fraction: one operand field suffices
	assign in_cmd.kind = kind;
	assign in_cmd.first = first;
	assign in_cmd.operand = kind ? random_fraction : fitness;
	assign busy = full;

	ifrs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.push(start), .push_cmd(in_cmd), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	ifrs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(not_empty), .cmd(head), .cmd_pop(pop),
		.res_valid(done), .res_index(chosen_index), .res_error(empty_error)
	);
endmodule
